@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file tot_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion clocked on clk, disabled in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion clocked on clk, also checked in reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tot_pkg.sv @@
// ----------------------------------------------------------------------------
// tot_pkg
// Shared sizes, codes, states and memory port structs of the 2-opt improver.
// ----------------------------------------------------------------------------
package tot_pkg;

  localparam int MAX_CITIES = 64;
  localparam int DIST_BITS  = 16;
  localparam int CITY_W     = $clog2(MAX_CITIES);
  localparam int DADDR_W    = 2 * CITY_W;
  localparam int LEN_W      = 7;
  localparam int PASS_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CNT_W      = $clog2(MAX_CITIES + 2);
  localparam int COST_W     = DIST_BITS + CITY_W;

  typedef enum logic [1:0] {
    CMD_LOAD_DIST = 2'd0,
    CMD_LOAD_TOUR = 2'd1,
    CMD_START     = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_TOUR_LENGTH = 1'b0,
    CFG_MAX_PASSES  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_PASS,
    S_EVAL,
    S_COPY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [CITY_W-1:0] waddr;
    logic [CITY_W-1:0] wdata;
    logic [CITY_W-1:0] raddr;
  } tour_port_t;

  typedef struct packed {
    logic                 we;
    logic [DADDR_W-1:0]   waddr;
    logic [DIST_BITS-1:0] wdata;
    logic [DADDR_W-1:0]   raddr;
  } dist_port_t;

endpackage

@@ hw/rtl/two_opt_tour_improver.sv @@
// ----------------------------------------------------------------------------
// two_opt_tour_improver
// 2-opt local search over a loaded open-path tour and distance matrix.
// ----------------------------------------------------------------------------
// Load items (distance entry, tour position) are written as they are accepted
// and busy stays low. A start item raises busy until the last result. Cost of
// a tour is found by streaming it through the tour memory and the distance
// memory; the start costs one such scan, then each (i, k) candidate costs one
// scan, and each accepted reversal adds a copy into the other tour bank. Each
// pass check is made in its own state. After a read of the first position,
// results come out one per cycle, one per position, strobed by out_valid,
// and cannot be held off by the receiver.
module two_opt_tour_improver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [tot_pkg::CITY_W-1:0] row_city,
  input  logic [tot_pkg::CITY_W-1:0] col_city,
  input  logic [15:0]                distance,
  input  logic [tot_pkg::CITY_W-1:0] tour_position,
  input  logic [tot_pkg::CITY_W-1:0] tour_city,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tot_pkg::CFG_W-1:0]  cfg_data,
  output logic                       out_valid,
  output logic [tot_pkg::CITY_W-1:0] out_position,
  output logic [tot_pkg::CITY_W-1:0] out_city,
  output logic                       last
);
  import tot_pkg::*;

  tour_port_t           tour0, tour1;
  dist_port_t           dmem;
  logic [CITY_W-1:0]    tour0_rdata, tour1_rdata;
  logic [DIST_BITS-1:0] dist_rdata;

  // sequencer
  tot_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .command, .row_city, .col_city, .distance,
    .tour_position, .tour_city, .cfg_we, .cfg_index, .cfg_data,
    .tour0, .tour1, .tour0_rdata, .tour1_rdata, .dmem, .dist_rdata,
    .out_valid, .out_position, .out_city, .last
  );

  // distance matrix
  tot_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_CITIES * MAX_CITIES)) u_dist (
    .clk, .we(dmem.we), .waddr(dmem.waddr), .wdata(dmem.wdata),
    .raddr(dmem.raddr), .rdata(dist_rdata)
  );

  // two tour banks, one current and one copy target
  tot_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour0 (
    .clk, .we(tour0.we), .waddr(tour0.waddr), .wdata(tour0.wdata),
    .raddr(tour0.raddr), .rdata(tour0_rdata)
  );

  tot_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour1 (
    .clk, .we(tour1.we), .waddr(tour1.waddr), .wdata(tour1.wdata),
    .raddr(tour1.raddr), .rdata(tour1_rdata)
  );

endmodule

@@ hw/rtl/tot_ram.sv @@
// ----------------------------------------------------------------------------
// tot_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tot_ctrl.sv @@
// ----------------------------------------------------------------------------
// tot_ctrl
// Sequencer: loads, cost evaluation pipeline, 2-opt loop, tour copy, output.
// ----------------------------------------------------------------------------
module tot_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [tot_pkg::CITY_W-1:0]   row_city,
  input  logic [tot_pkg::CITY_W-1:0]   col_city,
  input  logic [15:0]                  distance,
  input  logic [tot_pkg::CITY_W-1:0]   tour_position,
  input  logic [tot_pkg::CITY_W-1:0]   tour_city,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tot_pkg::CFG_W-1:0]    cfg_data,
  output tot_pkg::tour_port_t          tour0,
  output tot_pkg::tour_port_t          tour1,
  input  logic [tot_pkg::CITY_W-1:0]   tour0_rdata,
  input  logic [tot_pkg::CITY_W-1:0]   tour1_rdata,
  output tot_pkg::dist_port_t          dmem,
  input  logic [tot_pkg::DIST_BITS-1:0] dist_rdata,
  output logic                         out_valid,
  output logic [tot_pkg::CITY_W-1:0]   out_position,
  output logic [tot_pkg::CITY_W-1:0]   out_city,
  output logic                         last
);
  import tot_pkg::*;

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [LEN_W-1:0]    n_len, n_len_next;
  logic [CITY_W-1:0]   i_pos, i_pos_next;
  logic [CITY_W-1:0]   k_pos, k_pos_next;
  logic [COST_W-1:0]   acc, acc_next;
  logic [COST_W-1:0]   best_cost, best_cost_next;
  logic [PASS_W-1:0]   pass_count, pass_count_next;
  logic                improved, improved_next;
  logic                bank, bank_next;
  logic [CITY_W-1:0]   prev_city;
  logic [LEN_W-1:0]    tour_length;
  logic [PASS_W-1:0]   max_passes;

  logic                accept;
  logic [LEN_W-1:0]    eff_len;
  logic [CITY_W-1:0]   tour_rdata;
  logic [CITY_W-1:0]   c6;
  logic                swap_hit;
  logic [LEN_W-1:0]    mirror;
  logic [CITY_W-1:0]   rd_idx;
  logic                add_valid;
  logic                eval_end;
  logic [COST_W-1:0]   cost_now;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign eff_len = (tour_length > LEN_W'(MAX_CITIES)) ? LEN_W'(MAX_CITIES) : tour_length;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tour_length <= LEN_W'(64);
      max_passes  <= PASS_W'(1000);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TOUR_LENGTH: tour_length <= cfg_data[LEN_W-1:0];
        CFG_MAX_PASSES:  max_passes  <= cfg_data[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // read index: position i..k mirrored while a candidate is scanned or copied
  assign tour_rdata = bank ? tour1_rdata : tour0_rdata;
  assign c6         = cnt[CITY_W-1:0];
  assign swap_hit   = ((state == S_EVAL) || (state == S_COPY)) && (c6 >= i_pos) && (c6 <= k_pos);
  assign mirror     = LEN_W'(i_pos) + LEN_W'(k_pos) - LEN_W'(c6);
  assign rd_idx     = swap_hit ? mirror[CITY_W-1:0] : c6;

  // cost pipeline: tour read, distance read, accumulate
  assign add_valid = (cnt >= CNT_W'(3)) && (cnt <= CNT_W'(n_len) + CNT_W'(1));
  assign eval_end  = (cnt == CNT_W'(n_len) + CNT_W'(1));
  assign cost_now  = acc + (add_valid ? COST_W'(dist_rdata) : COST_W'(0));

  always_ff @(posedge clk) begin
    prev_city <= tour_rdata;
  end

  // memory ports
  always_comb begin
    dmem.we    = accept && (cmd_t'(command) == CMD_LOAD_DIST);
    dmem.waddr = {row_city, col_city};
    dmem.wdata = distance[DIST_BITS-1:0];
    dmem.raddr = {prev_city, tour_rdata};

    tour0.raddr = rd_idx;
    tour1.raddr = rd_idx;
    tour0.we    = 1'b0;
    tour1.we    = 1'b0;
    tour0.waddr = tour_position;
    tour1.waddr = tour_position;
    tour0.wdata = tour_city;
    tour1.wdata = tour_city;
    if (accept && (cmd_t'(command) == CMD_LOAD_TOUR)) begin
      tour0.we = !bank;
      tour1.we = bank;
    end else if ((state == S_COPY) && (cnt != '0)) begin
      // copy into the idle bank, one position a cycle
      tour0.we    = bank;
      tour1.we    = !bank;
      tour0.waddr = CITY_W'(cnt - CNT_W'(1));
      tour1.waddr = CITY_W'(cnt - CNT_W'(1));
      tour0.wdata = tour_rdata;
      tour1.wdata = tour_rdata;
    end
  end

  // results
  assign out_valid    = (state == S_EMIT) && (cnt != '0);
  assign out_position = CITY_W'(cnt - CNT_W'(1));
  assign out_city     = tour_rdata;
  assign last         = (cnt == CNT_W'(n_len));

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      n_len      <= '0;
      i_pos      <= '0;
      k_pos      <= '0;
      acc        <= '0;
      best_cost  <= '0;
      pass_count <= '0;
      improved   <= 1'b0;
      bank       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      n_len      <= n_len_next;
      i_pos      <= i_pos_next;
      k_pos      <= k_pos_next;
      acc        <= acc_next;
      best_cost  <= best_cost_next;
      pass_count <= pass_count_next;
      improved   <= improved_next;
      bank       <= bank_next;
    end
  end

  // next state
  always_comb begin
    logic do_adv;
    state_next      = state;
    cnt_next        = cnt;
    n_len_next      = n_len;
    i_pos_next      = i_pos;
    k_pos_next      = k_pos;
    acc_next        = acc;
    best_cost_next  = best_cost;
    pass_count_next = pass_count;
    improved_next   = improved;
    bank_next       = bank;
    do_adv          = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept && (cmd_t'(command) == CMD_START)) begin
          n_len_next = eff_len;
          cnt_next   = '0;
          acc_next   = '0;
          state_next = S_INIT;
        end
      end
      S_INIT, S_EVAL: begin
        cnt_next = cnt + CNT_W'(1);
        if (add_valid) begin
          acc_next = cost_now;
        end
        if (eval_end) begin
          acc_next = '0;
          cnt_next = '0;
          if (state == S_INIT) begin
            best_cost_next  = cost_now;
            improved_next   = 1'b1;
            pass_count_next = '0;
            state_next      = S_PASS;
          end else if (cost_now < best_cost) begin
            best_cost_next = cost_now;
            improved_next  = 1'b1;
            state_next     = S_COPY;
          end else begin
            do_adv = 1'b1;
          end
        end
      end
      S_COPY: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(MAX_CITIES)) begin
          cnt_next  = '0;
          bank_next = !bank;
          do_adv    = 1'b1;
        end
      end
      S_PASS: begin
        cnt_next = '0;
        if (improved && (pass_count < max_passes)) begin
          improved_next = 1'b0;
          if (n_len >= LEN_W'(4)) begin
            i_pos_next = CITY_W'(1);
            k_pos_next = CITY_W'(2);
            state_next = S_EVAL;
          end else begin
            pass_count_next = pass_count + PASS_W'(1);
          end
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cnt == CNT_W'(n_len)) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase

    // step to the next (i, k) pair or close the pass
    if (do_adv) begin
      if (LEN_W'(k_pos) + LEN_W'(2) < n_len) begin
        k_pos_next = k_pos + CITY_W'(1);
        state_next = S_EVAL;
      end else if (LEN_W'(i_pos) + LEN_W'(3) < n_len) begin
        i_pos_next = i_pos + CITY_W'(1);
        k_pos_next = i_pos + CITY_W'(2);
        state_next = S_EVAL;
      end else begin
        pass_count_next = pass_count + PASS_W'(1);
        state_next      = S_PASS;
      end
    end
  end

endmodule

@@ hw/rtl/tot_checker.sv @@
// ----------------------------------------------------------------------------
// tot_checker
// Port-level checks of the improver's busy and result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tot_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 command,
  input logic                       out_valid,
  input logic [tot_pkg::CITY_W-1:0] out_position,
  input logic                       last
);
  import tot_pkg::*;

  // results only while a start item is being worked
  `ASSERT_CLK(a_out_in_busy, out_valid |-> busy, "result outside busy window")

  // the final result ends the busy window
  `ASSERT_CLK(a_last_ends, (out_valid && last) |=> !busy, "busy after last result")

  // a start item always raises busy
  `ASSERT_CLK(a_start_busy, (start && !busy && (command == CMD_START)) |=> busy, "start ignored")

  // results count positions up by one
  `ASSERT_CLK(a_pos_step, (out_valid && !last) |=> (out_valid && (out_position == $past(out_position) + 1'b1)), "result positions not consecutive")

endmodule

bind two_opt_tour_improver tot_checker u_tot_checker (
  .clk, .rst, .start, .busy, .command, .out_valid, .out_position, .last
);

@@ tb/two_opt_checker.sv @@
// ----------------------------------------------------------------------------
// two_opt_checker
// Watches the item, config and result ports of the 2-opt improver, keeps its
// own copy of the distance matrix, tour and registers, predicts the emitted
// tour for every start item and compares each result field by field.
// ----------------------------------------------------------------------------
module two_opt_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 command,
  input  logic [tot_pkg::CITY_W-1:0] row_city,
  input  logic [tot_pkg::CITY_W-1:0] col_city,
  input  logic [15:0]                distance,
  input  logic [tot_pkg::CITY_W-1:0] tour_position,
  input  logic [tot_pkg::CITY_W-1:0] tour_city,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tot_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       out_valid,
  input  logic [tot_pkg::CITY_W-1:0] out_position,
  input  logic [tot_pkg::CITY_W-1:0] out_city,
  input  logic                       last,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tot_pkg::*;

  typedef bit [CITY_W-1:0] tour_arr_t [MAX_CITIES];

  typedef struct {
    bit [CITY_W-1:0] pos;
    bit [CITY_W-1:0] city;
    bit              fin;
  } tour_entry_t;

  tour_entry_t           expected_tour [$];
  bit [DIST_BITS-1:0]    dist_mem [MAX_CITIES*MAX_CITIES];
  tour_arr_t             tour_mem;
  int unsigned           len_reg;
  int unsigned           pass_cap;

  // open path cost over the first n positions
  function automatic int unsigned tour_cost(tour_arr_t t, int unsigned n);
    int unsigned sum;
    sum = 0;
    for (int unsigned p = 0; p + 1 < n; p++) sum += dist_mem[{t[p], t[p+1]}];
    return sum;
  endfunction

  // run 2-opt passes on tour_mem and queue the emitted tour
  function automatic void improve_and_queue();
    int unsigned n, passes, best, c;
    bit          improved;
    tour_arr_t   cand;
    tour_entry_t e;
    n = (len_reg > MAX_CITIES) ? MAX_CITIES : len_reg;
    improved = 1'b1;
    passes = 0;
    while (improved && passes < pass_cap) begin
      improved = 1'b0;
      best = tour_cost(tour_mem, n);
      for (int unsigned i = 1; i + 2 < n; i++) begin
        for (int unsigned k = i + 1; k + 1 < n; k++) begin
          cand = tour_mem;
          for (int unsigned p = i; p <= k; p++) cand[p] = tour_mem[k - (p - i)];
          c = tour_cost(cand, n);
          if (c < best) begin
            tour_mem = cand;
            best = c;
            improved = 1'b1;
          end
        end
      end
      passes++;
    end
    for (int unsigned p = 0; p < n; p++) begin
      e.pos = p[CITY_W-1:0];
      e.city = tour_mem[p];
      e.fin = (p + 1 == n);
      expected_tour.push_back(e);
    end
  endfunction

  // track ports at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      expected_tour.delete();
      len_reg = 64;
      pass_cap = 1000;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOUR_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          CFG_MAX_PASSES:  pass_cap = cfg_data[PASS_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (cmd_t'(command))
          CMD_LOAD_DIST: dist_mem[{row_city, col_city}] = distance;
          CMD_LOAD_TOUR: tour_mem[tour_position] = tour_city;
          CMD_START:     improve_and_queue();
          default: ;
        endcase
      end
      // compare each result with the oldest expectation
      if (out_valid) begin
        if (expected_tour.size() == 0) begin
          $error("unexpected result: position %0d city %0d", out_position, out_city);
          fail_count++;
        end else begin
          tour_entry_t e;
          e = expected_tour.pop_front();
          if (out_position !== e.pos) begin
            $error("out_position: expected %0d, actual %0d", e.pos, out_position);
            fail_count++;
          end
          if (out_city !== e.city) begin
            $error("out_city: expected %0d, actual %0d", e.city, out_city);
            fail_count++;
          end
          if (last !== e.fin) begin
            $error("last: expected %0d, actual %0d", e.fin, last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_tour.size();
  end

endmodule

@@ tb/tb_two_opt_tour_improver.sv @@
// ----------------------------------------------------------------------------
// tb_two_opt_tour_improver
// Drives load and start items into the 2-opt improver under several idle
// patterns and register settings; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_two_opt_tour_improver;
  timeunit 1ns;
  timeprecision 1ps;
  import tot_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command = CMD_NONE;
  logic [CITY_W-1:0] row_city = '0;
  logic [CITY_W-1:0] col_city = '0;
  logic [15:0]       distance = '0;
  logic [CITY_W-1:0] tour_position = '0;
  logic [CITY_W-1:0] tour_city = '0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_TOUR_LENGTH;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              out_valid;
  logic [CITY_W-1:0] out_position;
  logic [CITY_W-1:0] out_city;
  logic              last;
  int                fail_count;
  int                pending;

  // small city pool; 0 and 63 give every bit both values
  bit [CITY_W-1:0] city_pool [10] = '{0, 63, 5, 10, 21, 42, 17, 46, 33, 30};
  bit              dist_ok [MAX_CITIES*MAX_CITIES];
  bit              tour_ok [MAX_CITIES];
  bit              city_used [MAX_CITIES];
  int unsigned     cur_len = 64;
  int unsigned     gap_pct = 0;
  int              item_count = 0;

  always #5 clk = ~clk;

  two_opt_tour_improver u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .row_city(row_city), .col_city(col_city), .distance(distance),
    .tour_position(tour_position), .tour_city(tour_city), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
    .out_position(out_position), .out_city(out_city), .last(last)
  );

  two_opt_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .row_city(row_city), .col_city(col_city), .distance(distance),
    .tour_position(tour_position), .tour_city(tour_city), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
    .out_position(out_position), .out_city(out_city), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // hand one item over at the falling edge, with random sender gaps
  task automatic send_item(cmd_t cmd, bit [5:0] r, bit [5:0] c, bit [15:0] d,
                           bit [5:0] p, bit [5:0] ct);
    @(negedge clk);
    while (busy || $urandom_range(99) < gap_pct) begin
      start = 1'b0;
      command = 2'($urandom);
      distance = 16'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    row_city = r;
    col_city = c;
    distance = d;
    tour_position = p;
    tour_city = ct;
    item_count++;
    if (cmd == CMD_LOAD_DIST) dist_ok[{r, c}] = 1'b1;
    if (cmd == CMD_LOAD_TOUR) begin
      tour_ok[p] = 1'b1;
      city_used[ct] = 1'b1;
    end
  endtask

  function automatic bit [15:0] pick_distance();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom_range(200));
    endcase
  endfunction

  // wait until the block is idle and every result has come
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, bit [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == CFG_TOUR_LENGTH) cur_len = val[LEN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // make sure a start reads only written tour and distance entries
  task automatic fill_and_start();
    int unsigned n;
    n = (cur_len > MAX_CITIES) ? MAX_CITIES : cur_len;
    for (int p = 0; p < n; p++) begin
      if (!tour_ok[p])
        send_item(CMD_LOAD_TOUR, 0, 0, 0, 6'(p), city_pool[$urandom_range(9)]);
    end
    for (int a = 0; a < MAX_CITIES; a++) begin
      for (int b = 0; b < MAX_CITIES; b++) begin
        if (city_used[a] && city_used[b] && !dist_ok[{a[5:0], b[5:0]}])
          send_item(CMD_LOAD_DIST, 6'(a), 6'(b), pick_distance(), 0, 0);
      end
    end
    send_item(CMD_START, 6'($urandom), 6'($urandom), 16'($urandom), 6'($urandom),
              6'($urandom));
  endtask

  initial begin
    int unsigned seq;
    int unsigned r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero passes, largest cap, short lengths, oversized length
    write_cfg(CFG_TOUR_LENGTH, 4);
    write_cfg(CFG_MAX_PASSES, 0);
    send_item(CMD_LOAD_TOUR, 0, 0, 0, 0, 63);
    send_item(CMD_LOAD_TOUR, 0, 0, 0, 1, 0);
    send_item(CMD_LOAD_TOUR, 0, 0, 0, 2, 5);
    send_item(CMD_LOAD_TOUR, 0, 0, 0, 3, 10);
    send_item(CMD_LOAD_DIST, 63, 0, 16'hffff, 0, 0);
    send_item(CMD_LOAD_DIST, 0, 63, 16'd0, 0, 0);
    send_item(CMD_NONE, 63, 63, 16'hffff, 63, 63);
    fill_and_start();
    settle();
    write_cfg(CFG_MAX_PASSES, 16'hffff);
    fill_and_start();
    settle();
    write_cfg(CFG_TOUR_LENGTH, 3);
    fill_and_start();
    settle();
    write_cfg(CFG_TOUR_LENGTH, 0);
    fill_and_start();
    settle();
    write_cfg(CFG_TOUR_LENGTH, 7'h7f);
    write_cfg(CFG_MAX_PASSES, 1);
    fill_and_start();
    settle();

    // random sequences of loads, noise and starts
    seq = 0;
    while (item_count < 480) begin
      case ((seq / 8) % 4)
        0: gap_pct = 0;
        1: gap_pct = 64;
        2: gap_pct = 0;
        default: gap_pct = 15;
      endcase
      if ($urandom_range(99) < 35) begin
        r = $urandom_range(39);
        if (r == 0) write_cfg(CFG_TOUR_LENGTH, $urandom_range(1) ? 64 : 127);
        else if (r < 4) write_cfg(CFG_TOUR_LENGTH, 16'($urandom_range(3)));
        else write_cfg(CFG_TOUR_LENGTH, 16'($urandom_range(10, 4)));
        case ($urandom_range(5))
          0: write_cfg(CFG_MAX_PASSES, 0);
          1: write_cfg(CFG_MAX_PASSES, 16'hffff);
          2: write_cfg(CFG_MAX_PASSES, 1000);
          default: write_cfg(CFG_MAX_PASSES, 16'($urandom_range(5, 1)));
        endcase
      end
      // keep long tours to a single pass
      if (cur_len > 10) write_cfg(CFG_MAX_PASSES, 1);
      repeat ($urandom_range(6)) begin
        case ($urandom_range(3))
          0: send_item(CMD_LOAD_DIST, 6'($urandom), 6'($urandom), 16'($urandom),
                       6'($urandom), 6'($urandom));
          1: send_item(CMD_LOAD_TOUR, 0, 0, 0, 6'($urandom_range(cur_len > 0 ? 9 : 63)),
                       city_pool[$urandom_range(9)]);
          2: send_item(CMD_LOAD_TOUR, 0, 0, 0, 6'($urandom), city_pool[$urandom_range(9)]);
          default: send_item(CMD_NONE, 6'($urandom), 6'($urandom), 16'($urandom),
                             6'($urandom), 6'($urandom));
        endcase
      end
      fill_and_start();
      settle();
      seq++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #500_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
